// ===== sv/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// shared widths, event codes, register indexes and bundle types of the
// checksummed frame parser
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // register indexes, selected by paddr[2]
  localparam logic REG_IDX_HEADER = 1'b0;
  localparam logic REG_IDX_LIMIT  = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
  localparam logic [LEN_W-1:0]  LIMIT_RESET  = 6'd32;

  typedef enum logic [KIND_W-1:0] {
    EVT_DATA    = 2'd0,
    EVT_LEN_ERR = 2'd1,
    EVT_SUM_ERR = 2'd2
  } evt_kind_e;

  // request from the parser to the emitter, one cycle wide
  typedef struct packed {
    logic              valid;
    evt_kind_e         kind;
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
  } emit_req_t;

  // running counters, value after the last accepted byte
  typedef struct packed {
    logic [CNT_W-1:0] bytes_seen;
    logic [CNT_W-1:0] good_frames;
    logic [CNT_W-1:0] len_faults;
    logic [CNT_W-1:0] sum_faults;
  } cnt_t;

endpackage

// ===== sv/cfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// cfp_byte_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface cfp_byte_if;

  logic                       valid;
  logic                       ready;
  logic [cfp_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);

endinterface

// ===== sv/cfp_event_if.sv =====
// ----------------------------------------------------------------------------
// cfp_event_if
// result channel, one transaction per payload byte, empty frame or error event
// ----------------------------------------------------------------------------
interface cfp_event_if;

  logic                       valid;
  logic                       ready;
  logic [cfp_pkg::KIND_W-1:0] event_kind;
  logic [cfp_pkg::BYTE_W-1:0] frame_command;
  logic [cfp_pkg::LEN_W-1:0]  frame_length;
  logic [cfp_pkg::POS_W-1:0]  byte_position;
  logic [cfp_pkg::BYTE_W-1:0] payload_value;
  logic                       last_of_run;
  logic [cfp_pkg::CNT_W-1:0]  bytes_seen_count;
  logic [cfp_pkg::CNT_W-1:0]  good_frame_count;
  logic [cfp_pkg::CNT_W-1:0]  length_fault_count;
  logic [cfp_pkg::CNT_W-1:0]  sum_fault_count;

  modport source (
    output valid, output event_kind, output frame_command, output frame_length,
    output byte_position, output payload_value, output last_of_run,
    output bytes_seen_count, output good_frame_count, output length_fault_count,
    output sum_fault_count, input ready
  );
  modport sink (
    input valid, input event_kind, input frame_command, input frame_length,
    input byte_position, input payload_value, input last_of_run,
    input bytes_seen_count, input good_frame_count, input length_fault_count,
    input sum_fault_count, output ready
  );

endinterface

// ===== sv/cfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// apb register file: header byte and payload length limit
// ----------------------------------------------------------------------------
module cfp_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [cfp_pkg::ADDR_W-1:0] paddr_i,
  input  logic [cfp_pkg::DATA_W-1:0] pwdata_i,
  output logic [cfp_pkg::DATA_W-1:0] prdata_o,
  output logic                       pready_o,
  output logic [cfp_pkg::BYTE_W-1:0] header_o,
  output logic [cfp_pkg::LEN_W-1:0]  limit_o
);

  logic [cfp_pkg::BYTE_W-1:0] header_q, header_d;
  logic [cfp_pkg::LEN_W-1:0]  limit_q, limit_d;
  logic                       wr_en;

  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    header_d = header_q;
    limit_d  = limit_q;
    if (wr_en) begin
      case (paddr_i[2])
        cfp_pkg::REG_IDX_HEADER: header_d = pwdata_i[cfp_pkg::BYTE_W-1:0];
        cfp_pkg::REG_IDX_LIMIT:  limit_d  = pwdata_i[cfp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= cfp_pkg::HEADER_RESET;
      limit_q  <= cfp_pkg::LIMIT_RESET;
    end else begin
      header_q <= header_d;
      limit_q  <= limit_d;
    end
  end

  always_comb begin
    case (paddr_i[2])
      cfp_pkg::REG_IDX_HEADER: prdata_o = cfp_pkg::DATA_W'(header_q);
      cfp_pkg::REG_IDX_LIMIT:  prdata_o = cfp_pkg::DATA_W'(limit_q);
      default:                 prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;
  assign header_o = header_q;
  assign limit_o  = limit_q;

endmodule

// ===== sv/cfp_payload_ram.sv =====
// ----------------------------------------------------------------------------
// cfp_payload_ram
// payload byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module cfp_payload_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [cfp_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [cfp_pkg::BYTE_W-1:0] rdata_o
);

  logic [cfp_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [cfp_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cfp_parser.sv =====
// ----------------------------------------------------------------------------
// cfp_parser
// frame state machine: length check, running sum, payload writes, counters
// ----------------------------------------------------------------------------
module cfp_parser #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW          = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cfp_byte_if.sink                   in_i,
  input  logic                       em_idle_i,
  input  logic [cfp_pkg::BYTE_W-1:0] header_i,
  input  logic [cfp_pkg::LEN_W-1:0]  limit_i,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [cfp_pkg::BYTE_W-1:0] ram_wdata_o,
  output cfp_pkg::emit_req_t         req_o,
  output cfp_pkg::cnt_t              cnt_o
);

  localparam logic [cfp_pkg::BYTE_W-1:0] MaxLen = cfp_pkg::BYTE_W'(MAX_PAYLOAD);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_COMMAND = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SUM     = 5'b10000
  } phase_e;

  phase_e                     phase_q, phase_d, restart;
  logic [cfp_pkg::LEN_W-1:0]  len_q, len_d, fill_q, fill_d, fill_inc;
  logic [cfp_pkg::BYTE_W-1:0] cmd_q, cmd_d, sum_q, sum_d, sum_add, lim, b;
  cfp_pkg::cnt_t              cnt_q, cnt_d;
  logic                       accept;

  assign in_i.ready = em_idle_i;
  assign accept     = in_i.valid & em_idle_i;
  assign b          = in_i.data_byte;
  assign lim        = (cfp_pkg::BYTE_W'(limit_i) > MaxLen) ? MaxLen
                                                           : cfp_pkg::BYTE_W'(limit_i);
  assign sum_add    = cfp_pkg::BYTE_W'(sum_q + b);
  assign fill_inc   = cfp_pkg::LEN_W'(fill_q + 1'b1);
  // the byte that closes a frame may open the next one
  assign restart    = (b == header_i) ? PH_LENGTH : PH_HEADER;

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = fill_q[AW-1:0];
    ram_wdata_o = b;
    req_o       = '{valid: 1'b0, kind: cfp_pkg::EVT_DATA, cmd: '0, len: '0};
    if (accept) begin
      cnt_d.bytes_seen = cnt_q.bytes_seen + 1'b1;
      case (phase_q)
        PH_LENGTH: begin
          if (b > lim) begin
            cnt_d.len_faults = cnt_q.len_faults + 1'b1;
            req_o   = '{valid: 1'b1, kind: cfp_pkg::EVT_LEN_ERR, cmd: '0, len: '0};
            len_d   = '0;
            cmd_d   = '0;
            fill_d  = '0;
            sum_d   = '0;
            phase_d = restart;
          end else begin
            len_d   = b[cfp_pkg::LEN_W-1:0];
            sum_d   = b;
            phase_d = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          cmd_d   = b;
          sum_d   = sum_add;
          fill_d  = '0;
          phase_d = (len_q == '0) ? PH_SUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          ram_we_o = 1'b1;
          fill_d   = fill_inc;
          sum_d    = sum_add;
          if (fill_inc >= len_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          if (b == sum_q) begin
            cnt_d.good_frames = cnt_q.good_frames + 1'b1;
            req_o = '{valid: 1'b1, kind: cfp_pkg::EVT_DATA, cmd: cmd_q, len: len_q};
          end else begin
            cnt_d.sum_faults = cnt_q.sum_faults + 1'b1;
            req_o = '{valid: 1'b1, kind: cfp_pkg::EVT_SUM_ERR, cmd: '0, len: '0};
          end
          len_d   = '0;
          cmd_d   = '0;
          fill_d  = '0;
          sum_d   = '0;
          phase_d = restart;
        end
        default: begin
          // waiting for header
          phase_d = restart;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      len_q   <= '0;
      cmd_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ===== sv/cfp_emitter.sv =====
// ----------------------------------------------------------------------------
// cfp_emitter
// result sequencer: reads buffered payload back and drives the output register
// ----------------------------------------------------------------------------
module cfp_emitter #(
  parameter int unsigned AW = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfp_pkg::emit_req_t         req_i,
  input  cfp_pkg::cnt_t              cnt_i,
  input  logic [cfp_pkg::BYTE_W-1:0] ram_rdata_i,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  output logic                       idle_o,
  cfp_event_if.source                out_o
);

  typedef enum logic [2:0] {
    EM_IDLE   = 3'b001,
    EM_SINGLE = 3'b010,
    EM_LOAD   = 3'b100
  } em_state_e;

  em_state_e                  state_q, state_d;
  cfp_pkg::evt_kind_e         kind_q, kind_d;
  logic [cfp_pkg::BYTE_W-1:0] cmd_q, cmd_d;
  logic [cfp_pkg::LEN_W-1:0]  len_q, len_d, idx_q, idx_d, idx_inc;
  logic                       last;
  logic                       out_free;
  logic                       load;

  // output register
  logic                       ovalid_q, ovalid_d;
  logic [cfp_pkg::KIND_W-1:0] okind_q, okind_d;
  logic [cfp_pkg::BYTE_W-1:0] ocmd_q, ocmd_d, oval_q, oval_d;
  logic [cfp_pkg::LEN_W-1:0]  olen_q, olen_d;
  logic [cfp_pkg::POS_W-1:0]  opos_q, opos_d;
  logic                       olast_q, olast_d;
  cfp_pkg::cnt_t              ocnt_q, ocnt_d;

  assign out_free = ~ovalid_q | out_o.ready;
  assign idx_inc  = cfp_pkg::LEN_W'(idx_q + 1'b1);
  assign last     = (idx_inc == len_q);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    idx_d       = idx_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    load        = 1'b0;
    okind_d     = okind_q;
    ocmd_d      = ocmd_q;
    olen_d      = olen_q;
    opos_d      = opos_q;
    oval_d      = oval_q;
    olast_d     = olast_q;
    ocnt_d      = ocnt_q;
    case (state_q)
      EM_IDLE: begin
        if (req_i.valid) begin
          kind_d = req_i.kind;
          cmd_d  = req_i.cmd;
          len_d  = req_i.len;
          idx_d  = '0;
          if (req_i.kind == cfp_pkg::EVT_DATA && req_i.len != '0) begin
            ram_re_o = 1'b1;
            state_d  = EM_LOAD;
          end else begin
            state_d = EM_SINGLE;
          end
        end
      end
      EM_SINGLE: begin
        // error event or empty frame
        if (out_free) begin
          load    = 1'b1;
          okind_d = kind_q;
          ocmd_d  = cmd_q;
          olen_d  = len_q;
          opos_d  = '0;
          oval_d  = '0;
          olast_d = 1'b1;
          ocnt_d  = cnt_i;
          state_d = EM_IDLE;
        end
      end
      EM_LOAD: begin
        // read data for idx_q is valid, held while the output stalls
        if (out_free) begin
          load    = 1'b1;
          okind_d = cfp_pkg::EVT_DATA;
          ocmd_d  = cmd_q;
          olen_d  = len_q;
          opos_d  = idx_q[cfp_pkg::POS_W-1:0];
          oval_d  = ram_rdata_i;
          olast_d = last;
          ocnt_d  = cnt_i;
          if (last) begin
            state_d = EM_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_inc[AW-1:0];
            idx_d       = idx_inc;
          end
        end
      end
      default: state_d = EM_IDLE;
    endcase
    ovalid_d = load | (ovalid_q & ~out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EM_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    cmd_q   <= cmd_d;
    len_q   <= len_d;
    idx_q   <= idx_d;
    okind_q <= okind_d;
    ocmd_q  <= ocmd_d;
    olen_q  <= olen_d;
    opos_q  <= opos_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
    ocnt_q  <= ocnt_d;
  end

  assign idle_o                   = (state_q == EM_IDLE);
  assign out_o.valid              = ovalid_q;
  assign out_o.event_kind         = okind_q;
  assign out_o.frame_command      = ocmd_q;
  assign out_o.frame_length       = olen_q;
  assign out_o.byte_position      = opos_q;
  assign out_o.payload_value      = oval_q;
  assign out_o.last_of_run        = olast_q;
  assign out_o.bytes_seen_count   = ocnt_q.bytes_seen;
  assign out_o.good_frame_count   = ocnt_q.good_frames;
  assign out_o.length_fault_count = ocnt_q.len_faults;
  assign out_o.sum_fault_count    = ocnt_q.sum_faults;

endmodule

// ===== sv/checksummed_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_parser_core
// parses header/length/command/payload/sum8 frames from a byte stream and
// delivers each good frame as one transaction per payload byte, an empty
// frame or a length or sum error as a single transaction
//
//   port      dir  kind          carries
//   in_i      in   valid/ready   data_byte, one received byte per transaction
//   out_o     out  valid/ready   frame data or error event plus counters
//   apb       in   psel/penable  header_byte at 0x0, payload_limit at 0x4
//
// a byte that causes no result is taken without hold-off; an error or an empty
// frame holds the input off while its event is loaded, a good frame while each
// payload byte is read back, one payload ram read per result
// a result waiting in a stalled output register stretches the hold-off
// the output register lets the next byte in while a result waits to be taken
// reset is asynchronous, active low; no clearing pass, the payload ram is
// only read at entries written by the current frame
// ----------------------------------------------------------------------------
module checksummed_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cfp_byte_if.sink                   in_i,
  cfp_event_if.source                out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfp_pkg::ADDR_W-1:0] paddr,
  input  logic [cfp_pkg::DATA_W-1:0] pwdata,
  output logic [cfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  // payload ram address width, at least one bit
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [cfp_pkg::BYTE_W-1:0] header;
  logic [cfp_pkg::LEN_W-1:0]  limit;
  logic                       em_idle;
  cfp_pkg::emit_req_t         em_req;
  cfp_pkg::cnt_t              cnt;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [cfp_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  cfp_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .header_o  (header),
    .limit_o   (limit)
  );

  // frame parsing; takes a byte only while the emitter is idle, so payload
  // writes and readback never touch the ram in the same cycle
  cfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .em_idle_i   (em_idle),
    .header_i    (header),
    .limit_i     (limit),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .req_o       (em_req),
    .cnt_o       (cnt)
  );

  cfp_payload_ram #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result sequencing; counters are stable while it runs since no byte is taken
  cfp_emitter #(
    .AW (AW)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (em_req),
    .cnt_i       (cnt),
    .ram_rdata_i (ram_rdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .idle_o      (em_idle),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // payload write and readback never share a cycle
  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("payload ram read and write in the same cycle");

  // a readback is always followed by a cycle with the input held off
  a_read_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> !in_i.ready)
    else $error("input accepted while payload readback pending");

  // no byte slips in between results of one run
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_of_run) |-> !in_i.ready)
    else $error("input accepted in the middle of a result run");

  // results are only requested by an accepted byte
  a_req_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_req.valid |-> (in_i.valid && in_i.ready))
    else $error("result request without accepted byte");
`endif

endmodule
